FILE: hdl/conv_pkg.sv
// Shared types, constants and codes for the strided zero-padded convolution point block.
// Used by conv_regs, conv_ctrl, conv_dp, conv2d_relu_point and conv_chk.
`default_nettype none

package conv_pkg;

  localparam int DATA_WIDTH         = 16;
  localparam int FRAC_SHIFT         = DATA_WIDTH / 2;
  localparam int ACT_W              = 15;
  localparam int ACT_MAX            = 32767;
  localparam int DEF_MAX_IMAGE_DIM  = 32;
  localparam int DEF_MAX_KERNEL_DIM = 8;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 5;
  localparam int IMG_DIM_W = 6;
  localparam int KER_DIM_W = 4;
  localparam int STEP_W    = 3;
  localparam int PAD_W     = 3;
  localparam int CMP_W     = 10;
  localparam int ADDR_W    = 5;
  localparam int PDATA_W   = 32;

  localparam logic [IMG_DIM_W-1:0] RST_IMAGE_ROWS  = IMG_DIM_W'(28);
  localparam logic [IMG_DIM_W-1:0] RST_IMAGE_COLS  = IMG_DIM_W'(28);
  localparam logic [KER_DIM_W-1:0] RST_KERNEL_ROWS = KER_DIM_W'(5);
  localparam logic [KER_DIM_W-1:0] RST_KERNEL_COLS = KER_DIM_W'(5);
  localparam logic [STEP_W-1:0]    RST_STEP_SIZE   = STEP_W'(1);
  localparam logic [PAD_W-1:0]     RST_PAD_WIDTH   = PAD_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_WR_PIXEL  = 2'd0,
    OP_WR_WEIGHT = 2'd1,
    OP_COMPUTE   = 2'd2
  } conv_op_t;

  typedef enum logic [2:0] {
    REG_IMAGE_ROWS  = 3'd0,
    REG_IMAGE_COLS  = 3'd1,
    REG_KERNEL_ROWS = 3'd2,
    REG_KERNEL_COLS = 3'd3,
    REG_STEP_SIZE   = 3'd4,
    REG_PAD_WIDTH   = 3'd5
  } conv_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_TAPS,
    ST_DRAIN,
    ST_RESULT
  } conv_state_t;

  typedef struct packed {
    logic [IMG_DIM_W-1:0] image_rows;
    logic [IMG_DIM_W-1:0] image_cols;
    logic [KER_DIM_W-1:0] kernel_rows;
    logic [KER_DIM_W-1:0] kernel_cols;
    logic [STEP_W-1:0]    step_size;
    logic [PAD_W-1:0]     pad_width;
  } conv_cfg_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic tap;
    logic load_out;
  } conv_cmd_t;

  typedef struct packed {
    logic run;
    logic tap_last;
    logic pipe_busy;
    logic out_free;
  } conv_sts_t;

endpackage

`default_nettype wire

FILE: hdl/conv_regs.sv
// APB-style configuration registers for the convolution point block.
// Depends on conv_pkg for register codes, widths and reset values.
`default_nettype none

module conv_regs
  import conv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output conv_cfg_t               cfg
);

  conv_cfg_t        cfg_r;
  conv_cfg_t        cfg_nxt;
  logic [2:0]       reg_idx;
  logic             wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_IMAGE_ROWS:  cfg_nxt.image_rows  = pwdata[IMG_DIM_W-1:0];
        REG_IMAGE_COLS:  cfg_nxt.image_cols  = pwdata[IMG_DIM_W-1:0];
        REG_KERNEL_ROWS: cfg_nxt.kernel_rows = pwdata[KER_DIM_W-1:0];
        REG_KERNEL_COLS: cfg_nxt.kernel_cols = pwdata[KER_DIM_W-1:0];
        REG_STEP_SIZE:   cfg_nxt.step_size   = pwdata[STEP_W-1:0];
        REG_PAD_WIDTH:   cfg_nxt.pad_width   = pwdata[PAD_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_ROWS:  prdata = PDATA_W'(cfg_r.image_rows);
      REG_IMAGE_COLS:  prdata = PDATA_W'(cfg_r.image_cols);
      REG_KERNEL_ROWS: prdata = PDATA_W'(cfg_r.kernel_rows);
      REG_KERNEL_COLS: prdata = PDATA_W'(cfg_r.kernel_cols);
      REG_STEP_SIZE:   prdata = PDATA_W'(cfg_r.step_size);
      REG_PAD_WIDTH:   prdata = PDATA_W'(cfg_r.pad_width);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_rows  <= RST_IMAGE_ROWS;
      cfg_r.image_cols  <= RST_IMAGE_COLS;
      cfg_r.kernel_rows <= RST_KERNEL_ROWS;
      cfg_r.kernel_cols <= RST_KERNEL_COLS;
      cfg_r.step_size   <= RST_STEP_SIZE;
      cfg_r.pad_width   <= RST_PAD_WIDTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/conv_ctrl.sv
// Controller state machine: sequences accept, setup, tap loop and drain (compute items only), and result hand-off.
// Depends on conv_pkg for the state, command and status types.
`default_nettype none

module conv_ctrl
  import conv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire conv_sts_t sts,
  output conv_cmd_t      cmd
);

  conv_state_t state_r;
  conv_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.run ? ST_TAPS : ST_RESULT;
      end
      ST_TAPS: begin
        cmd.tap = 1'b1;
        if (sts.tap_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/conv_dp.sv
// Datapath: item registers, range checks, image and kernel memories, MAC pipeline, output register.
// Depends on conv_pkg for widths, opcodes and the command, status and config types.
`default_nettype none

module conv_dp
  import conv_pkg::*;
#(
  parameter int MAX_IMAGE_DIM  = DEF_MAX_IMAGE_DIM,
  parameter int MAX_KERNEL_DIM = DEF_MAX_KERNEL_DIM
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire conv_cmd_t                    cmd,
  output conv_sts_t                         sts,
  input  wire conv_cfg_t                    cfg,
  input  wire logic        [OP_W-1:0]       in_operation,
  input  wire logic        [IDX_W-1:0]      in_row_index,
  input  wire logic        [IDX_W-1:0]      in_col_index,
  input  wire logic signed [DATA_WIDTH-1:0] in_sample_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic             [ACT_W-1:0]      out_activation,
  output logic                              out_status
);

  localparam int IMG_DEPTH = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
  localparam int IMG_AW    = $clog2(IMG_DEPTH);
  localparam int KER_DEPTH = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
  localparam int KER_AW    = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
  localparam int PROD_W    = 2 * DATA_WIDTH;
  localparam int ACC_W     = PROD_W + $clog2(KER_DEPTH) + 1;
  localparam logic signed [ACC_W-1:0] ACT_MAX_S = ACC_W'(ACT_MAX);

  logic signed [DATA_WIDTH-1:0] img_mem [IMG_DEPTH];
  logic signed [DATA_WIDTH-1:0] ker_mem [KER_DEPTH];

  logic        [OP_W-1:0]       op_r;
  logic        [IDX_W-1:0]      row_r;
  logic        [IDX_W-1:0]      col_r;
  logic signed [DATA_WIDTH-1:0] val_r;
  logic                         err_r;
  logic signed [CMP_W-1:0]      base_row_r;
  logic signed [CMP_W-1:0]      base_col_r;
  logic        [KER_DIM_W-1:0]  tap_row_r;
  logic        [KER_DIM_W-1:0]  tap_col_r;
  logic signed [DATA_WIDTH-1:0] img_q_r;
  logic signed [DATA_WIDTH-1:0] ker_q_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic                         v1_r;
  logic                         v2_r;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic        [ACT_W-1:0]      out_act_r;
  logic                         out_status_r;

  logic        [CMP_W-1:0]      row_w;
  logic        [CMP_W-1:0]      col_w;
  logic        [CMP_W-1:0]      img_rows_w;
  logic        [CMP_W-1:0]      img_cols_w;
  logic        [CMP_W-1:0]      ker_rows_w;
  logic        [CMP_W-1:0]      ker_cols_w;
  logic        [CMP_W-1:0]      pad2_w;
  logic        [CMP_W-1:0]      ys;
  logic        [CMP_W-1:0]      xs;
  logic                         pix_ok;
  logic                         wgt_ok;
  logic                         cfg_ok;
  logic                         y_ok;
  logic                         x_ok;
  logic                         err_nxt;
  logic                         wr_pix;
  logic                         wr_wgt;
  logic        [IMG_AW-1:0]     wr_img_addr;
  logic        [KER_AW-1:0]     wr_ker_addr;
  logic signed [CMP_W-1:0]      pr;
  logic signed [CMP_W-1:0]      pc;
  logic                         tap_in;
  logic        [IMG_AW-1:0]     rd_img_addr;
  logic        [KER_AW-1:0]     rd_ker_addr;
  logic                         col_wrap;
  logic signed [ACC_W-1:0]      acc_shift;
  logic        [ACT_W-1:0]      act_nxt;

  assign row_w      = CMP_W'(row_r);
  assign col_w      = CMP_W'(col_r);
  assign img_rows_w = CMP_W'(cfg.image_rows);
  assign img_cols_w = CMP_W'(cfg.image_cols);
  assign ker_rows_w = CMP_W'(cfg.kernel_rows);
  assign ker_cols_w = CMP_W'(cfg.kernel_cols);
  assign pad2_w     = CMP_W'(cfg.pad_width) << 1;
  assign ys         = row_w * CMP_W'(cfg.step_size);
  assign xs         = col_w * CMP_W'(cfg.step_size);

  assign pix_ok = (row_w < img_rows_w) && (col_w < img_cols_w) &&
                  (row_w < CMP_W'(MAX_IMAGE_DIM)) && (col_w < CMP_W'(MAX_IMAGE_DIM));
  assign wgt_ok = (row_w < ker_rows_w) && (col_w < ker_cols_w) &&
                  (row_w < CMP_W'(MAX_KERNEL_DIM)) && (col_w < CMP_W'(MAX_KERNEL_DIM));
  assign cfg_ok = (img_rows_w != '0) && (img_rows_w <= CMP_W'(MAX_IMAGE_DIM)) &&
                  (img_cols_w != '0) && (img_cols_w <= CMP_W'(MAX_IMAGE_DIM)) &&
                  (ker_rows_w != '0) && (ker_rows_w <= CMP_W'(MAX_KERNEL_DIM)) &&
                  (ker_cols_w != '0) && (ker_cols_w <= CMP_W'(MAX_KERNEL_DIM)) &&
                  (cfg.step_size != '0);
  assign y_ok   = (ys + ker_rows_w) <= (img_rows_w + pad2_w);
  assign x_ok   = (xs + ker_cols_w) <= (img_cols_w + pad2_w);

  always_comb begin
    unique case (op_r)
      OP_WR_PIXEL:  err_nxt = !pix_ok;
      OP_WR_WEIGHT: err_nxt = !wgt_ok;
      OP_COMPUTE:   err_nxt = !(cfg_ok && y_ok && x_ok);
      default:      err_nxt = 1'b1;
    endcase
  end

  assign wr_pix = cmd.setup && (op_r == OP_WR_PIXEL) && pix_ok;
  assign wr_wgt = cmd.setup && (op_r == OP_WR_WEIGHT) && wgt_ok;
  assign wr_img_addr = IMG_AW'(IMG_AW'(row_r) * IMG_AW'(MAX_IMAGE_DIM) + IMG_AW'(col_r));
  assign wr_ker_addr = KER_AW'(KER_AW'(row_r) * KER_AW'(MAX_KERNEL_DIM) + KER_AW'(col_r));

  assign pr = base_row_r + $signed(CMP_W'(tap_row_r));
  assign pc = base_col_r + $signed(CMP_W'(tap_col_r));
  assign tap_in = !pr[CMP_W-1] && ($unsigned(pr) < img_rows_w) &&
                  !pc[CMP_W-1] && ($unsigned(pc) < img_cols_w);
  assign rd_img_addr = IMG_AW'(IMG_AW'($unsigned(pr)) * IMG_AW'(MAX_IMAGE_DIM) +
                               IMG_AW'($unsigned(pc)));
  assign rd_ker_addr = KER_AW'(KER_AW'(tap_row_r) * KER_AW'(MAX_KERNEL_DIM) +
                               KER_AW'(tap_col_r));
  assign col_wrap = (tap_col_r == cfg.kernel_cols - KER_DIM_W'(1));

  assign sts.run       = (op_r == OP_COMPUTE) && !err_nxt;
  assign sts.tap_last  = col_wrap && (tap_row_r == cfg.kernel_rows - KER_DIM_W'(1));
  assign sts.pipe_busy = v1_r || v2_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign acc_shift = acc_r >>> FRAC_SHIFT;

  always_comb begin
    if (acc_r[ACC_W-1] || (acc_r == '0)) begin
      act_nxt = '0;
    end else if (acc_shift > ACT_MAX_S) begin
      act_nxt = ACT_W'(ACT_MAX);
    end else begin
      act_nxt = acc_shift[ACT_W-1:0];
    end
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_pix) begin
      img_mem[wr_img_addr] <= val_r;
    end
    if (cmd.tap) begin
      img_q_r <= img_mem[rd_img_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_wgt) begin
      ker_mem[wr_ker_addr] <= val_r;
    end
    if (cmd.tap) begin
      ker_q_r <= ker_mem[rd_ker_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= cmd.tap && tap_in;
      v2_r        <= v1_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      row_r <= in_row_index;
      col_r <= in_col_index;
      val_r <= in_sample_value;
    end
    if (cmd.setup) begin
      err_r      <= err_nxt;
      base_row_r <= $signed(ys) - $signed(CMP_W'(cfg.pad_width));
      base_col_r <= $signed(xs) - $signed(CMP_W'(cfg.pad_width));
      tap_row_r  <= '0;
      tap_col_r  <= '0;
    end else if (cmd.tap) begin
      if (col_wrap) begin
        tap_col_r <= '0;
        tap_row_r <= tap_row_r + KER_DIM_W'(1);
      end else begin
        tap_col_r <= tap_col_r + KER_DIM_W'(1);
      end
    end
    prod_r <= img_q_r * ker_q_r;
    if (cmd.setup) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.load_out) begin
      out_act_r    <= act_nxt;
      out_status_r <= err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_activation = out_act_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

FILE: hdl/conv2d_relu_point.sv
// Top level of the zero-padded, strided single-channel convolution point with ReLU.
// Instantiates conv_regs, conv_ctrl and conv_dp; depends on conv_pkg.
//
// Each input word writes one Q8.8 pixel, writes one Q8.8 kernel weight, or computes one
// output point, and gives exactly one result word (activation, status). Writes and bad
// items go from setup straight to the result hand-off and back to idle. A compute item
// passes setup, then one tap per kernel position (a multiply-accumulate for each tap
// inside the image), paced by the single read port of the image and kernel memories,
// then a drain of the read/multiply/accumulate pipeline, the result hand-off and the
// return to idle. A finished result waits in the output register while the next word
// is accepted. Stores are not cleared: read only entries already written. No reset
// sweep is needed.
`default_nettype none

module conv2d_relu_point
  import conv_pkg::*;
#(
  parameter int MAX_IMAGE_DIM  = DEF_MAX_IMAGE_DIM,
  parameter int MAX_KERNEL_DIM = DEF_MAX_KERNEL_DIM
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic        [OP_W-1:0]       in_operation,
  input  wire logic        [IDX_W-1:0]      in_row_index,
  input  wire logic        [IDX_W-1:0]      in_col_index,
  input  wire logic signed [DATA_WIDTH-1:0] in_sample_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic             [ACT_W-1:0]      out_activation,
  output logic                              out_status,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic        [ADDR_W-1:0]     paddr,
  input  wire logic        [PDATA_W-1:0]    pwdata,
  output logic             [PDATA_W-1:0]    prdata,
  output logic                              pready
);

  conv_cfg_t cfg;
  conv_cmd_t cmd;
  conv_sts_t sts;

  conv_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  conv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  conv_dp #(
    .MAX_IMAGE_DIM  (MAX_IMAGE_DIM),
    .MAX_KERNEL_DIM (MAX_KERNEL_DIM)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg             (cfg),
    .in_operation    (in_operation),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_activation  (out_activation),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire

FILE: hdl/conv_chk.sv
// Port-level checker for conv2d_relu_point and the bind that attaches it.
// Depends on conv_pkg for field widths.
`default_nettype none

module conv_chk
  import conv_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [ACT_W-1:0] out_activation,
  input wire logic             out_status
);

  logic [1:0] pending_r;
  logic [1:0] pending_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && !out_acc) begin
      pending_nxt = pending_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pending_nxt = pending_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pending_r != 2'd0))
    else $error("result word without an accepted input word");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r == 2'd2) |-> in_stall)
    else $error("input accepted with two words already outstanding");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_activation == '0))
    else $error("error result carries nonzero activation");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_activation) && $stable(out_status)))
    else $error("stalled result word dropped or changed");

endmodule

bind conv2d_relu_point conv_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_activation (out_activation),
  .out_status     (out_status)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking bench for conv2d_relu_point: pixel/weight writes and strided, zero-padded
// convolution points with ReLU, predicted in-bench and compared word by word.
// Depends on conv_pkg and the conv2d_relu_point RTL.
module tb;
  import conv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IMG_DIM = DEF_MAX_IMAGE_DIM;
  localparam int KER_DIM = DEF_MAX_KERNEL_DIM;
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  typedef struct {
    logic [OP_W-1:0]              op;
    logic [IDX_W-1:0]             row;
    logic [IDX_W-1:0]             col;
    logic signed [DATA_WIDTH-1:0] sample;
  } point_word_t;

  typedef struct {
    logic [ACT_W-1:0] activation;
    logic             status;
  } point_res_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [OP_W-1:0]              in_operation = '0;
  logic [IDX_W-1:0]             in_row_index = '0;
  logic [IDX_W-1:0]             in_col_index = '0;
  logic signed [DATA_WIDTH-1:0] in_sample_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [ACT_W-1:0]             out_activation;
  logic                         out_status;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [ADDR_W-1:0]            paddr = '0;
  logic [PDATA_W-1:0]           pwdata = '0;
  logic [PDATA_W-1:0]           prdata;
  logic                         pready;

  conv_cfg_t    cfg;
  logic signed [DATA_WIDTH-1:0] pixel_mem [IMG_DIM*IMG_DIM];
  logic signed [DATA_WIDTH-1:0] weight_mem [KER_DIM*KER_DIM];
  bit           pixel_seen [IMG_DIM*IMG_DIM];
  bit           weight_seen [KER_DIM*KER_DIM];
  int           tap_px[$];
  int           tap_wt[$];
  point_word_t  word_backlog[$];
  point_res_t   pending_results[$];
  point_word_t  next_word;
  point_res_t   want;
  int           words_queued = 0;
  int           send_idle = 0;
  int           recv_idle = 0;
  int           err_count = 0;

  conv2d_relu_point u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_sample_value(in_sample_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_activation (out_activation),
    .out_status     (out_status),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic conv_cfg_t mk_cfg(int ir, int ic, int kr, int kc, int st, int pd);
    conv_cfg_t c;
    c.image_rows  = IMG_DIM_W'(ir);
    c.image_cols  = IMG_DIM_W'(ic);
    c.kernel_rows = KER_DIM_W'(kr);
    c.kernel_cols = KER_DIM_W'(kc);
    c.step_size   = STEP_W'(st);
    c.pad_width   = PAD_W'(pd);
    return c;
  endfunction

  function automatic bit cfg_usable();
    return cfg.image_rows >= 1 && cfg.image_rows <= IMG_DIM &&
           cfg.image_cols >= 1 && cfg.image_cols <= IMG_DIM &&
           cfg.kernel_rows >= 1 && cfg.kernel_rows <= KER_DIM &&
           cfg.kernel_cols >= 1 && cfg.kernel_cols <= KER_DIM &&
           cfg.step_size != 0;
  endfunction

  function automatic int out_len(int img, int ker);
    int padded;
    padded = img + 2 * int'(cfg.pad_width);
    if (padded < ker) return 0;
    return (padded - ker) / int'(cfg.step_size) + 1;
  endfunction

  // store address written by a word under the current settings, -1 if rejected
  function automatic int store_slot(logic [OP_W-1:0] op, int r, int c);
    if (op == OP_WR_PIXEL && r < int'(cfg.image_rows) && c < int'(cfg.image_cols) &&
        r < IMG_DIM && c < IMG_DIM)
      return r * IMG_DIM + c;
    if (op == OP_WR_WEIGHT && r < int'(cfg.kernel_rows) && c < int'(cfg.kernel_cols) &&
        r < KER_DIM && c < KER_DIM)
      return r * KER_DIM + c;
    return -1;
  endfunction

  // collect the pixel/weight pairs of one output point; 0 if the point is rejected
  function automatic bit gather_window(int y, int x);
    int rows, cols, kr, kc, st, pd, pr, pc;
    tap_px.delete();
    tap_wt.delete();
    if (!cfg_usable()) return 0;
    rows = cfg.image_rows;
    cols = cfg.image_cols;
    kr   = cfg.kernel_rows;
    kc   = cfg.kernel_cols;
    st   = cfg.step_size;
    pd   = cfg.pad_width;
    if (y >= out_len(rows, kr) || x >= out_len(cols, kc)) return 0;
    for (int i = 0; i < kr; i++) begin
      pr = y * st + i - pd;
      if (pr < 0 || pr >= rows) continue;
      for (int j = 0; j < kc; j++) begin
        pc = x * st + j - pd;
        if (pc < 0 || pc >= cols) continue;
        tap_px.push_back(pr * IMG_DIM + pc);
        tap_wt.push_back(i * KER_DIM + j);
      end
    end
    return 1;
  endfunction

  function automatic void predict_point(logic [OP_W-1:0] op, logic [IDX_W-1:0] r,
                                        logic [IDX_W-1:0] c, logic signed [DATA_WIDTH-1:0] v);
    point_res_t res;
    longint     acc;
    int         slot;
    res.activation = '0;
    res.status     = 1'b1;
    slot = store_slot(op, r, c);
    if (op == OP_WR_PIXEL && slot >= 0) begin
      pixel_mem[slot] = v;
      res.status = 1'b0;
    end else if (op == OP_WR_WEIGHT && slot >= 0) begin
      weight_mem[slot] = v;
      res.status = 1'b0;
    end else if (op == OP_COMPUTE && gather_window(r, c)) begin
      acc = 0;
      foreach (tap_px[k])
        acc += longint'(pixel_mem[tap_px[k]]) * longint'(weight_mem[tap_wt[k]]);
      res.status = 1'b0;
      if (acc > 0)
        res.activation = (acc >>> FRAC_SHIFT) > ACT_MAX ? ACT_W'(ACT_MAX)
                                                         : ACT_W'(acc >>> FRAC_SHIFT);
    end
    pending_results.push_back(res);
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] rand_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return -16'sd1;
        endcase
      end
      1, 2: return DATA_WIDTH'($urandom);
      default: return DATA_WIDTH'(int'($urandom_range(1024)) - 512);
    endcase
  endfunction

  function automatic int pick_below(int n, int lim);
    if (n < 1 || n > lim) return $urandom_range(31);
    return $urandom_range(n - 1);
  endfunction

  function automatic void push_word(logic [OP_W-1:0] op, int r, int c,
                                    logic signed [DATA_WIDTH-1:0] v);
    int slot;
    word_backlog.push_back('{op, IDX_W'(r), IDX_W'(c), v});
    words_queued++;
    slot = store_slot(op, r, c);
    if (op == OP_WR_PIXEL && slot >= 0) pixel_seen[slot] = 1'b1;
    if (op == OP_WR_WEIGHT && slot >= 0) weight_seen[slot] = 1'b1;
  endfunction

  // write any window entry not yet loaded, then ask for the point
  function automatic void push_compute(int y, int x);
    if (gather_window(y, x)) begin
      foreach (tap_px[k])
        if (!pixel_seen[tap_px[k]])
          push_word(OP_WR_PIXEL, tap_px[k] / IMG_DIM, tap_px[k] % IMG_DIM, rand_sample());
      foreach (tap_wt[k])
        if (!weight_seen[tap_wt[k]])
          push_word(OP_WR_WEIGHT, tap_wt[k] / KER_DIM, tap_wt[k] % KER_DIM, rand_sample());
    end
    push_word(OP_COMPUTE, y, x, DATA_WIDTH'($urandom));
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (word_backlog.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(conv_reg_t idx, logic [PDATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_config(conv_cfg_t c);
    wait_idle();
    write_reg(REG_IMAGE_ROWS, PDATA_W'(c.image_rows));
    write_reg(REG_IMAGE_COLS, PDATA_W'(c.image_cols));
    write_reg(REG_KERNEL_ROWS, PDATA_W'(c.kernel_rows));
    write_reg(REG_KERNEL_COLS, PDATA_W'(c.kernel_cols));
    write_reg(REG_STEP_SIZE, PDATA_W'(c.step_size));
    write_reg(REG_PAD_WIDTH, PDATA_W'(c.pad_width));
    cfg = c;
  endtask

  task automatic sweep(conv_cfg_t c, int n_words, int s_idle, int r_idle);
    int start, pick, ex_r, ex_c, y, x;
    apply_config(c);
    send_idle = s_idle;
    recv_idle = r_idle;
    start = words_queued;
    while (words_queued - start < n_words) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        y = $urandom_range(31);
        x = $urandom_range(31);
        if (cfg_usable()) begin
          ex_r = out_len(cfg.image_rows, cfg.kernel_rows);
          ex_c = out_len(cfg.image_cols, cfg.kernel_cols);
          if (ex_r > 0) y = $urandom_range((ex_r > 32 ? 32 : ex_r) - 1);
          if (ex_c > 0) x = $urandom_range((ex_c > 32 ? 32 : ex_c) - 1);
        end
        push_compute(y, x);
      end else if (pick < 55) begin
        push_compute($urandom_range(31), $urandom_range(31));
      end else if (pick < 75) begin
        push_word(OP_WR_PIXEL, pick_below(cfg.image_rows, IMG_DIM),
                  pick_below(cfg.image_cols, IMG_DIM), rand_sample());
      end else if (pick < 87) begin
        push_word(OP_WR_WEIGHT, pick_below(cfg.kernel_rows, KER_DIM),
                  pick_below(cfg.kernel_cols, KER_DIM), rand_sample());
      end else if (pick < 96) begin
        push_word($urandom_range(1) ? OP_WR_WEIGHT : OP_WR_PIXEL, $urandom_range(31),
                  $urandom_range(31), rand_sample());
      end else begin
        push_word(OP_UNKNOWN, $urandom_range(31), $urandom_range(31), DATA_WIDTH'($urandom));
      end
    end
  endtask

  // driver: predict on acceptance, then present the next word or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predict_point(in_operation, in_row_index, in_col_index, in_sample_value);
      if (!in_valid || !in_stall) begin
        if (word_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_word = word_backlog.pop_front();
          in_operation    <= next_word.op;
          in_row_index    <= next_word.row;
          in_col_index    <= next_word.col;
          in_sample_value <= next_word.sample;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, compare each accepted word
  always @(posedge clk) begin
    out_stall <= recv_idle > 0 && $urandom_range(99) < recv_idle;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word activation=%0d status=%0d", $time, out_activation,
                 out_status);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_activation !== want.activation) begin
          $display("%0t: activation mismatch expected=%0d actual=%0d", $time,
                   want.activation, out_activation);
          err_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d", $time, want.status,
                   out_status);
          err_count++;
        end
      end
    end
  end

  initial begin
    cfg = mk_cfg(RST_IMAGE_ROWS, RST_IMAGE_COLS, RST_KERNEL_ROWS, RST_KERNEL_COLS,
                 RST_STEP_SIZE, RST_PAD_WIDTH);
    send_idle = 34;
    recv_idle = 87;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes seen through range checks only
    push_word(OP_WR_PIXEL, 27, 27, 16'sh7fff);
    push_word(OP_WR_PIXEL, 28, 0, 16'sh1234);
    push_word(OP_WR_WEIGHT, 4, 4, 16'sh8000);
    push_word(OP_WR_WEIGHT, 5, 0, 16'sh0100);
    push_compute(28, 0);
    push_compute(0, 28);
    push_word(OP_UNKNOWN, 31, 31, -16'sd1);

    // 2x2 image, 2x2 kernel, pad 1: corners, saturation, ReLU clamp, range edge
    apply_config(mk_cfg(2, 2, 2, 2, 1, 1));
    push_word(OP_WR_PIXEL, 0, 0, 16'sh7fff);
    push_word(OP_WR_PIXEL, 0, 1, 16'sh8000);
    push_word(OP_WR_PIXEL, 1, 0, 16'sh0100);
    push_word(OP_WR_PIXEL, 1, 1, 16'sh0000);
    push_word(OP_WR_WEIGHT, 0, 0, 16'sh7fff);
    push_word(OP_WR_WEIGHT, 0, 1, 16'sh8000);
    push_word(OP_WR_WEIGHT, 1, 0, 16'sh0100);
    push_word(OP_WR_WEIGHT, 1, 1, 16'sh0100);
    push_compute(0, 0);
    push_compute(1, 1);
    push_compute(0, 1);
    push_compute(2, 2);
    push_compute(3, 0);

    // illegal register settings reject a compute
    apply_config(mk_cfg(0, 2, 2, 2, 1, 1));
    push_compute(0, 0);
    apply_config(mk_cfg(2, 33, 2, 2, 1, 1));
    push_compute(0, 0);
    apply_config(mk_cfg(2, 2, 9, 2, 1, 1));
    push_compute(0, 0);
    apply_config(mk_cfg(2, 2, 2, 2, 0, 1));
    push_compute(0, 0);

    sweep(mk_cfg(28, 28, 5, 5, 1, 2), 220, 34, 87);
    sweep(mk_cfg(32, 32, 8, 8, 4, 4), 200, 34, 87);
    sweep(mk_cfg(1, 1, 1, 1, 1, 0), 120, 34, 87);
    sweep(mk_cfg(7, 13, 3, 2, 2, 1), 200, 87, 34);
    sweep(mk_cfg(32, 1, 8, 1, 3, 4), 200, 87, 34);
    sweep(mk_cfg(5, 9, 4, 6, 1, 0), 200, 87, 34);
    sweep(mk_cfg(3, 3, 8, 8, 1, 1), 120, 0, 0);
    sweep(mk_cfg(32, 32, 2, 2, 7, 0), 220, 0, 0);
    sweep(mk_cfg(63, 0, 15, 0, 0, 0), 120, 0, 0);
    sweep(mk_cfg(16, 20, 3, 3, 2, 7), 200, 0, 0);

    wait_idle();
    repeat (80) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
